### rtl/i2c_adc_config_and_read_master_defines.svh
// Assertion macros used by the I2C converter read master RTL.
// No dependencies; included by i2cacm_seq, the only module that carries assertions.
`ifndef I2C_ADC_CONFIG_AND_READ_MASTER_DEFINES_SVH
`define I2C_ADC_CONFIG_AND_READ_MASTER_DEFINES_SVH

// checked only while out of reset
`define I2CACM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// checked at every edge, reset included
`define I2CACM_ASSERT_NR(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

### rtl/i2cacm_pkg.sv
// Shared types, constants and byte table for the I2C converter read master.
// No dependencies; imported by every module of the block.
package i2cacm_pkg;

  localparam int TIMER_W   = 10;
  localparam int PHASE_W   = 10;
  localparam int CMP_W     = (TIMER_W > PHASE_W) ? TIMER_W : PHASE_W;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 16;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WR_ADDR  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TEMPLATE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LONG     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SHORT    = 3'd3;

  // byte positions within the whole sequence
  localparam logic [2:0] BYTE_ADDR_CFG = 3'd0;
  localparam logic [2:0] BYTE_PTR_CFG  = 3'd1;
  localparam logic [2:0] BYTE_CFG_HI   = 3'd2;
  localparam logic [2:0] BYTE_CFG_LO   = 3'd3;
  localparam logic [2:0] BYTE_ADDR_PTR = 3'd4;
  localparam logic [2:0] BYTE_PTR_CONV = 3'd5;
  localparam logic [2:0] BYTE_RD_ADDR  = 3'd6;
  localparam logic [2:0] BYTE_RX       = 3'd7;

  localparam logic [7:0] PTR_CONFIG = 8'h01;
  localparam logic [7:0] PTR_CONV   = 8'h00;

  // per-step line levels and phase length select, bit n = step n
  localparam logic [20:0] SCL_TAB  = 21'b110001001001000100111;
  localparam logic [20:0] SDA_TAB  = 21'b100000011111110000011;
  localparam logic [20:0] LONG_TAB = 21'b111101011111001111110;

  typedef struct packed {
    logic [7:0]         wr_addr;
    logic [15:0]        tmpl;
    logic [PHASE_W-1:0] long_ticks;
    logic [PHASE_W-1:0] short_ticks;
  } cfg_t;

  typedef struct packed {
    logic        scl;
    logic        sda;
    logic        busy;
    logic        done;
    logic [15:0] reading;
  } res_t;

  function automatic logic [7:0] tx_byte(input logic [2:0]  idx,
                                         input logic [7:0]  addr,
                                         input logic [15:0] tmpl,
                                         input logic [1:0]  ch);
    logic [15:0] word;
    logic [7:0]  b;
    word = {tmpl[15], 1'b1, ch, tmpl[11:0]};
    unique case (idx)
      BYTE_ADDR_CFG, BYTE_ADDR_PTR: b = addr;
      BYTE_PTR_CFG:                 b = PTR_CONFIG;
      BYTE_CFG_HI:                  b = word[15:8];
      BYTE_CFG_LO:                  b = word[7:0];
      BYTE_PTR_CONV:                b = PTR_CONV;
      BYTE_RD_ADDR:                 b = addr + 8'd1;
      default:                      b = 8'd0;
    endcase
    return b;
  endfunction

endpackage

### rtl/i2cacm_cfg.sv
// Configuration register file of the I2C converter read master.
// Depends on i2cacm_pkg.
module i2cacm_cfg
  import i2cacm_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data,
  output cfg_t                 cfg
);

  cfg_t cfg_r;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.wr_addr     <= 8'd144;
      cfg_r.tmpl        <= 16'd33155;
      cfg_r.long_ticks  <= PHASE_W'(15);
      cfg_r.short_ticks <= PHASE_W'(1);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_WR_ADDR:  cfg_r.wr_addr     <= cfg_data[7:0];
        REG_TEMPLATE: cfg_r.tmpl        <= cfg_data[15:0];
        REG_LONG:     cfg_r.long_ticks  <= cfg_data[PHASE_W-1:0];
        REG_SHORT:    cfg_r.short_ticks <= cfg_data[PHASE_W-1:0];
        default: ; // unknown index, dropped
      endcase
    end
  end

endmodule

### rtl/i2cacm_seq.sv
// Bus sequencer of the I2C converter read master: step, timer, bit/byte counts.
// Depends on i2cacm_pkg and the assertion macro header.
`include "i2c_adc_config_and_read_master_defines.svh"

module i2cacm_seq
  import i2cacm_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_acc,
  input  logic       action,
  input  logic [1:0] channel,
  input  logic       sda_in,
  input  cfg_t       cfg,
  output res_t       res
);

  typedef enum logic [4:0] {
    S_IDLE       = 5'd0,
    S_START_REL  = 5'd1,
    S_START_LO   = 5'd2,
    S_START_SCL  = 5'd3,
    S_TX_SETUP   = 5'd4,
    S_TX_HI      = 5'd5,
    S_TX_LO      = 5'd6,
    S_ACK_REL    = 5'd7,
    S_ACK_SETUP  = 5'd8,
    S_ACK_HI     = 5'd9,
    S_ACK_LO     = 5'd10,
    S_RX_SETUP   = 5'd11,
    S_RX_HI      = 5'd12,
    S_RX_LO      = 5'd13,
    S_MACK_SETUP = 5'd14,
    S_MACK_HI    = 5'd15,
    S_MACK_LO    = 5'd16,
    S_MACK_REL   = 5'd17,
    S_STOP_SETUP = 5'd18,
    S_STOP_HI    = 5'd19,
    S_STOP_REL   = 5'd20
  } step_t;

  localparam logic [CMP_W-1:0] TIMER_MAX = CMP_W'((1 << TIMER_W) - 1);

  step_t              step_r, step_nxt, step_cur;
  logic [TIMER_W-1:0] timer_r, timer_nxt, timer_base, timer_inc;
  logic [3:0]         bit_r, bit_nxt, bit_base;
  logic [2:0]         byte_r, byte_nxt, byte_base;
  logic [7:0]         shift_r, shift_nxt;
  logic [1:0]         ch_r, ch_nxt;
  logic [15:0]        reading_r, reading_nxt;
  logic [15:0]        rx_r, rx_nxt;
  logic [CMP_W-1:0]   dur;
  logic [PHASE_W-1:0] dur_sel;
  logic               nack;
  res_t               res_c;

  always_comb begin
    step_cur   = step_r;
    timer_base = timer_r;
    bit_base   = bit_r;
    byte_base  = byte_r;
    ch_nxt     = ch_r;
    shift_nxt  = shift_r;
    reading_nxt = reading_r;
    rx_nxt     = rx_r;
    res_c      = '{scl: 1'b1, sda: 1'b1, busy: 1'b0, done: 1'b0, reading: 16'd0};

    if (step_cur == S_IDLE && action) begin
      ch_nxt     = channel;
      step_cur   = S_START_REL;
      timer_base = '0;
      bit_base   = '0;
      byte_base  = '0;
    end

    step_nxt  = step_cur;
    timer_nxt = timer_base;
    bit_nxt   = bit_base;
    byte_nxt  = byte_base;
    timer_inc = timer_base + TIMER_W'(1);
    nack      = (bit_base == 4'd0);

    dur_sel = LONG_TAB[step_cur] ? cfg.long_ticks : cfg.short_ticks;
    dur     = CMP_W'(dur_sel);
    if (dur == '0)
      dur = CMP_W'(1);
    if (dur > TIMER_MAX)
      dur = TIMER_MAX;

    if (step_cur != S_IDLE) begin
      res_c.busy = 1'b1;
      res_c.scl  = SCL_TAB[step_cur];
      if (step_cur == S_TX_SETUP || step_cur == S_TX_HI || step_cur == S_TX_LO)
        res_c.sda = shift_r[7];
      else if (step_cur == S_MACK_REL)
        res_c.sda = ~nack;
      else if (step_cur == S_MACK_SETUP || step_cur == S_MACK_HI ||
               step_cur == S_MACK_LO)
        res_c.sda = nack;
      else
        res_c.sda = SDA_TAB[step_cur];

      if (CMP_W'(timer_inc) >= dur) begin
        timer_nxt = '0;
        unique case (step_cur)
          S_START_SCL: begin
            shift_nxt = tx_byte(byte_base, cfg.wr_addr, cfg.tmpl, ch_nxt);
            bit_nxt   = '0;
            step_nxt  = S_TX_SETUP;
          end
          S_TX_LO: begin
            shift_nxt = {shift_r[6:0], 1'b0};
            bit_nxt   = bit_base + 4'd1;
            step_nxt  = (bit_nxt == 4'd8) ? S_ACK_REL : S_TX_SETUP;
          end
          S_ACK_HI: begin
            shift_nxt = {7'd0, sda_in};
            step_nxt  = S_ACK_LO;
          end
          S_ACK_LO: begin
            if (shift_r == 8'd0) begin
              if (byte_base == BYTE_CFG_LO || byte_base == BYTE_PTR_CONV) begin
                byte_nxt = byte_base + 3'd1;
                step_nxt = S_STOP_SETUP;
              end else if (byte_base >= BYTE_RD_ADDR) begin
                byte_nxt = BYTE_RX;
                bit_nxt  = '0;
                rx_nxt   = '0;
                step_nxt = S_RX_SETUP;
              end else begin
                byte_nxt  = byte_base + 3'd1;
                shift_nxt = tx_byte(byte_nxt, cfg.wr_addr, cfg.tmpl, ch_nxt);
                bit_nxt   = '0;
                step_nxt  = S_TX_SETUP;
              end
            end else begin
              // slave nack: stop, then redo this transaction from its first byte
              if (byte_base <= BYTE_CFG_LO)
                byte_nxt = BYTE_ADDR_CFG;
              else if (byte_base <= BYTE_PTR_CONV)
                byte_nxt = BYTE_ADDR_PTR;
              else
                byte_nxt = BYTE_RD_ADDR;
              step_nxt = S_STOP_SETUP;
            end
          end
          S_RX_HI: begin
            rx_nxt   = {rx_r[14:0], sda_in};
            bit_nxt  = bit_base + 4'd1;
            step_nxt = S_RX_LO;
          end
          S_RX_LO: begin
            step_nxt = (bit_base == 4'd8 || bit_base == 4'd0) ? S_MACK_SETUP : S_RX_SETUP;
          end
          S_MACK_REL: begin
            step_nxt = (bit_base == 4'd0) ? S_STOP_SETUP : S_RX_SETUP;
          end
          S_STOP_REL: begin
            if (byte_base == BYTE_RX) begin
              reading_nxt = rx_r;
              res_c.done  = 1'b1;
              byte_nxt    = '0;
              step_nxt    = S_IDLE;
            end else begin
              step_nxt = S_START_REL;
            end
          end
          S_START_REL, S_START_LO, S_TX_SETUP, S_TX_HI, S_ACK_REL, S_ACK_SETUP,
          S_RX_SETUP, S_MACK_SETUP, S_MACK_HI, S_MACK_LO, S_STOP_SETUP,
          S_STOP_HI: begin
            step_nxt = step_t'(step_cur + 5'd1);
          end
          default: step_nxt = S_IDLE;
        endcase
      end else begin
        timer_nxt = timer_inc;
      end
    end

    res_c.reading = reading_nxt;
  end

  assign res = res_c;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r    <= S_IDLE;
      timer_r   <= '0;
      bit_r     <= '0;
      byte_r    <= '0;
      shift_r   <= '0;
      ch_r      <= '0;
      reading_r <= '0;
      rx_r      <= '0;
    end else if (in_acc) begin
      step_r    <= step_nxt;
      timer_r   <= timer_nxt;
      bit_r     <= bit_nxt;
      byte_r    <= byte_nxt;
      shift_r   <= shift_nxt;
      ch_r      <= ch_nxt;
      reading_r <= reading_nxt;
      rx_r      <= rx_nxt;
    end
  end

  `I2CACM_ASSERT_NR(a_reset_idle, !rst_n |=> step_r == S_IDLE, "step not idle after reset")
  `I2CACM_ASSERT(a_idle_released, in_acc && step_r == S_IDLE && !action |-> !res.busy && res.scl && res.sda, "idle tick drives the bus")
  `I2CACM_ASSERT(a_start_step, in_acc && step_r == S_IDLE && action |=> step_r == S_START_REL || step_r == S_START_LO, "request did not open a start")
  `I2CACM_ASSERT(a_done_idle, in_acc && res.done |=> step_r == S_IDLE && byte_r == BYTE_ADDR_CFG, "done without return to idle")
  `I2CACM_ASSERT(a_hold, !in_acc |=> $stable(step_r) && $stable(timer_r), "state moved without a word")

endmodule

### rtl/i2c_adc_config_and_read_master.sv
// Top level of the I2C converter read master: ports, register file, sequencer,
// output register. Depends on i2cacm_pkg, i2cacm_cfg and i2cacm_seq.
//
// Every input word is one tick of the bus time base and yields exactly one
// output word carrying the line levels for that tick. One word is taken per
// clock: the sequencer updates its step, phase timer and bit/byte counters on
// each accepted word and the result lands in a single output register, so
// in_tready only drops while that register holds a word the sink has not
// taken. A read runs from the word that accepts the request through start,
// config write, pointer write and two-byte read, each line phase lasting the
// long or short tick count; done_res marks the word whose reading is new.
// Configuration writes are taken at any time and apply from the next accepted
// word on; make them while no word is in flight.
module i2c_adc_config_and_read_master
  import i2cacm_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [7:0]           in_tdata,   // [1:0] channel, [2] sda_sample, rest zero
  input  logic [0:0]           in_tuser,   // [0] action
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [23:0]          out_tdata,  // [0] scl_level, [1] sda_level,
                                           // [2] busy_res, [18:3] reading, rest zero
  output logic [0:0]           out_tuser,  // [0] done_res
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data
);

  cfg_t cfg;
  res_t res;
  res_t res_r;
  logic out_valid_r;
  logic in_acc;

  assign in_tready = !out_valid_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;

  i2cacm_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  i2cacm_seq u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_acc  (in_acc),
    .action  (in_tuser[0]),
    .channel (in_tdata[1:0]),
    .sda_in  (in_tdata[2]),
    .cfg     (cfg),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_tready) begin
      out_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      res_r <= res;
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = {5'd0, res_r.reading, res_r.busy, res_r.sda, res_r.scl};
  assign out_tuser[0] = res_r.done;

endmodule
